FILE: rtl/core/scr_pkg.sv
package scr_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int STATE_COUNT   = 256;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $clog2(STATE_COUNT);
  localparam int CW = $clog2(STATE_COUNT + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RESTART   = 3'd1;
  localparam logic [2:0] ST_CONFLICT  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  localparam logic FUNC_STEP   = 1'b0;
  localparam logic FUNC_DEFINE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  symbol;
    logic        symbol_is_default;
    logic        seq_last;
    logic [15:0] def_mods;
    logic [15:0] def_key;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] mods;
    logic [15:0] out_key;
    logic [7:0]  next_state;
    logic [2:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic [SW-1:0] src;
    logic [7:0]    sym;
    logic          dflt;
    logic [SW-1:0] dst;
    logic [15:0]   mods;
    logic [15:0]   key;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/scancode_sequence_recognizer.sv
// a new input beat is taken only once the previous one has been resolved; the linear
// scan of the single-read-port transition memory reads one entry per cycle
// reset: synchronous active-low; clears fill count, parser state, insert cursor,
//   skip flag and state counter (to 1); table contents are ignored until written
module scancode_sequence_recognizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scr_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scr_pkg::out_beat_t out_data
);
  import scr_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  scr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  scr_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

FILE: rtl/core/scr_table.sv
module scr_table (
  input  logic              clk,
  input  scr_pkg::mem_req_t req,
  output scr_pkg::entry_t   rdata
);
  import scr_pkg::*;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/scr_ctrl.sv
module scr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scr_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scr_pkg::out_beat_t out_data,
  output scr_pkg::mem_req_t  mem_req,
  input  scr_pkg::entry_t    mem_rdata
);
  import scr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_SCAN    = 3'b010,
    S_RESOLVE = 3'b100
  } fsm_t;

  fsm_t          state_r, state_nxt;
  in_beat_t      in_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] scan_idx_r, scan_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] counter_r, counter_nxt;
  logic [SW-1:0] parser_r, parser_nxt;
  logic [SW-1:0] cursor_r, cursor_nxt;
  logic          skip_r, skip_nxt;
  logic          hit_a_r, hit_b_r;
  entry_t        ent_a_r, ent_b_r;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic          accept, issue, fire, full;
  logic          dflt_a, match_a, match_b;
  logic [SW-1:0] src_w;
  logic [SW+7:0] wide_state;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign issue    = (state_r == S_SCAN) && (scan_idx_r < used_r);
  assign fire     = (state_r == S_RESOLVE) && !(out_valid_r && out_stall);
  assign full     = (used_r == UW'(TABLE_ENTRIES));

  // search keys: exact (or define key) and default branch
  assign src_w   = (in_r.func == FUNC_DEFINE) ? cursor_r : parser_r;
  assign dflt_a  = (in_r.func == FUNC_DEFINE) && in_r.symbol_is_default;
  assign match_a = pend_r && (mem_rdata.src == src_w) && (mem_rdata.dflt == dflt_a) &&
                   (dflt_a || (mem_rdata.sym == in_r.symbol));
  assign match_b = pend_r && (in_r.func == FUNC_STEP) && (mem_rdata.src == src_w) &&
                   mem_rdata.dflt;

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = issue;
    used_nxt      = used_r;
    counter_nxt   = counter_r;
    parser_nxt    = parser_r;
    cursor_nxt    = cursor_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    mem_req.re    = issue;
    mem_req.raddr = scan_idx_r[AW-1:0];
    mem_req.waddr = used_r[AW-1:0];
    mem_req.wdata.src  = cursor_r;
    mem_req.wdata.sym  = in_r.symbol_is_default ? 8'd0 : in_r.symbol;
    mem_req.wdata.dflt = in_r.symbol_is_default;
    mem_req.wdata.dst  = '0;
    mem_req.wdata.mods = '0;
    mem_req.wdata.key  = '0;
    out_data_nxt.mods    = '0;
    out_data_nxt.out_key = '0;
    out_data_nxt.status  = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + UW'(1);
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (fire) begin
          state_nxt = S_IDLE;
          if (in_r.func == FUNC_DEFINE) begin
            if (skip_r) begin
              if (in_r.seq_last) begin
                skip_nxt   = 1'b0;
                cursor_nxt = '0;
              end
            end else if (in_r.seq_last) begin
              cursor_nxt = '0;
              if (hit_a_r) begin
                out_data_nxt.status = ST_CONFLICT;
              end else if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                mem_req.we         = 1'b1;
                mem_req.wdata.mods = in_r.def_mods;
                mem_req.wdata.key  = in_r.def_key;
                used_nxt           = used_r + UW'(1);
              end
            end else if (hit_a_r) begin
              cursor_nxt = ent_a_r.dst;
            end else if (full) begin
              out_data_nxt.status = ST_FULL;
              skip_nxt            = 1'b1;
            end else if (counter_r >= CW'(STATE_COUNT)) begin
              out_data_nxt.status = ST_EXHAUSTED;
              skip_nxt            = 1'b1;
            end else begin
              mem_req.we        = 1'b1;
              mem_req.wdata.dst = counter_r[SW-1:0];
              used_nxt          = used_r + UW'(1);
              cursor_nxt        = counter_r[SW-1:0];
              counter_nxt       = counter_r + CW'(1);
            end
          end else begin
            if (hit_a_r) begin
              out_data_nxt.mods    = ent_a_r.mods;
              out_data_nxt.out_key = ent_a_r.key;
              parser_nxt           = ent_a_r.dst;
            end else if (hit_b_r) begin
              out_data_nxt.mods    = ent_b_r.mods;
              out_data_nxt.out_key = ent_b_r.key;
              parser_nxt           = ent_b_r.dst;
            end else begin
              out_data_nxt.status = ST_RESTART;
              parser_nxt          = '0;
            end
          end
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    wide_state = {8'd0, (in_r.func == FUNC_DEFINE) ? cursor_nxt : parser_nxt};
    if (fire) begin
      out_data_nxt.next_state = wide_state[7:0];
    end else begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      counter_r   <= CW'(1);
      parser_r    <= '0;
      cursor_r    <= '0;
      skip_r      <= 1'b0;
      hit_a_r     <= 1'b0;
      hit_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      counter_r   <= counter_nxt;
      parser_r    <= parser_nxt;
      cursor_r    <= cursor_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        hit_a_r <= 1'b0;
        hit_b_r <= 1'b0;
      end else begin
        if (match_a) hit_a_r <= 1'b1;
        if (match_b) hit_b_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (match_a) begin
      ent_a_r <= mem_rdata;
    end
    if (match_b) begin
      ent_b_r <= mem_rdata;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counter_r <= CW'(STATE_COUNT) && counter_r != '0)
    else $error("state counter out of range");

  a_write_in_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_RESOLVE) && !mem_req.re)
    else $error("table write outside resolve");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN) && !hit_a_r && !hit_b_r)
    else $error("accepted beat did not start a clean scan");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("read data pending outside scan");

endmodule

FILE: bench/scr_reply_checker.sv
module scr_reply_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  scr_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  scr_pkg::out_beat_t out_data,
  output int                 mismatch_count,
  output int                 awaited
);
  import scr_pkg::*;

  typedef struct {
    int          src;
    logic [7:0]  sym;
    logic        dflt;
    int          dst;
    logic [15:0] mods;
    logic [15:0] key;
  } trans_t;

  trans_t    trans_tbl [TABLE_ENTRIES];
  int        trans_fill;
  int        fresh_state;
  int        parse_state;
  int        def_cursor;
  logic      def_skipping;
  out_beat_t reply_q [$];

  function automatic int find_trans(int src, logic [7:0] sym, logic dflt);
    for (int i = 0; i < trans_fill; i++) begin
      if (trans_tbl[i].src == src && trans_tbl[i].dflt == dflt &&
          (dflt || trans_tbl[i].sym == sym))
        return i;
    end
    return -1;
  endfunction

  function automatic void add_trans(int src, logic [7:0] sym, logic dflt, int dst,
                                    logic [15:0] mods, logic [15:0] key);
    trans_tbl[trans_fill] = '{src, dflt ? 8'd0 : sym, dflt, dst, mods, key};
    trans_fill++;
  endfunction

  function automatic out_beat_t recognizer_reply(in_beat_t b);
    out_beat_t r;
    int        idx;
    r = '0;
    r.status = ST_OK;
    if (b.func == FUNC_DEFINE) begin
      if (def_skipping) begin
        if (b.seq_last) begin
          def_skipping = 1'b0;
          def_cursor = 0;
        end
      end else begin
        idx = find_trans(def_cursor, b.symbol, b.symbol_is_default);
        if (b.seq_last) begin
          if (idx >= 0) begin
            r.status = ST_CONFLICT;
          end else if (trans_fill >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            add_trans(def_cursor, b.symbol, b.symbol_is_default, 0, b.def_mods, b.def_key);
          end
          def_cursor = 0;
        end else if (idx >= 0) begin
          def_cursor = trans_tbl[idx].dst;
        end else if (trans_fill >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
          def_skipping = 1'b1;
        end else if (fresh_state >= STATE_COUNT) begin
          r.status = ST_EXHAUSTED;
          def_skipping = 1'b1;
        end else begin
          add_trans(def_cursor, b.symbol, b.symbol_is_default, fresh_state, '0, '0);
          def_cursor = fresh_state;
          fresh_state++;
        end
      end
      r.next_state = def_cursor[7:0];
    end else begin
      idx = find_trans(parse_state, b.symbol, 1'b0);
      if (idx < 0)
        idx = find_trans(parse_state, 8'd0, 1'b1);
      if (idx < 0) begin
        parse_state = 0;
        r.status = ST_RESTART;
      end else begin
        r.mods = trans_tbl[idx].mods;
        r.out_key = trans_tbl[idx].key;
        parse_state = trans_tbl[idx].dst;
      end
      r.next_state = parse_state[7:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      trans_fill = 0;
      fresh_state = 1;
      parse_state = 0;
      def_cursor = 0;
      def_skipping = 1'b0;
      reply_q.delete();
    end else begin
      if (in_valid && !in_stall)
        reply_q.push_back(recognizer_reply(in_data));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with none awaited", out_data));
        end else begin
          want = reply_q.pop_front();
          if (out_data.mods !== want.mods || out_data.out_key !== want.out_key ||
              out_data.next_state !== want.next_state || out_data.status !== want.status)
            report_mismatch($sformatf(
              "mods %h key %h state %h status %0d, want mods %h key %h state %h status %0d",
              out_data.mods, out_data.out_key, out_data.next_state, out_data.status,
              want.mods, want.out_key, want.next_state, want.status));
        end
      end
    end
    awaited = reply_q.size();
  end

endmodule

FILE: bench/tb_scancode_sequence_recognizer.sv
module tb_scancode_sequence_recognizer;
  import scr_pkg::*;

  localparam int ITEMS_TOTAL = 800;
  localparam int CALM_TAIL   = 100;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       idle_on = 1'b0;
  int         stall_left = 0;
  int         beats_sent = 0;
  int         mismatch_count;
  int         awaited;
  logic [7:0] path [$];
  logic       path_dflt [$];
  int         walk = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  scancode_sequence_recognizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  scr_reply_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .awaited        (awaited)
  );

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_beat_t rand_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  task automatic send_beat(in_beat_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    beats_sent++;
    if (beats_sent % 40 == 0)
      idle_on <= (ITEMS_TOTAL - beats_sent > CALM_TAIL) && ($urandom_range(0, 2) != 0);
  endtask

  task automatic step_code(logic [7:0] sym);
    in_beat_t b;
    b = rand_beat();
    b.func = FUNC_STEP;
    b.symbol = sym;
    send_beat(b);
  endtask

  task automatic define_elem(logic [7:0] sym, logic dflt, logic last);
    in_beat_t b;
    b = rand_beat();
    b.func = FUNC_DEFINE;
    b.symbol = sym;
    b.symbol_is_default = dflt;
    b.seq_last = last;
    send_beat(b);
  endtask

  // follow the long chain from state 0, now and then break off
  task automatic walk_step();
    if (walk < path.size() && $urandom_range(0, 7) != 0) begin
      step_code(path[walk]);
      walk++;
    end else begin
      step_code(8'($urandom));
      walk = 0;
    end
  endtask

  task automatic define_sequence();
    int   depth;
    int   tail;
    logic last;
    depth = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    if (depth > path.size())
      depth = path.size();
    tail = $urandom_range(1, 3);
    for (int i = 0; i < depth; i++)
      define_elem(path[i], path_dflt[i], 1'b0);
    for (int i = 0; i < tail; i++) begin
      last = (i == tail - 1);
      if (depth + i < path.size() && $urandom_range(0, 1) == 0)
        define_elem(path[depth + i], path_dflt[depth + i], last);
      else
        define_elem(8'($urandom), $urandom_range(0, 7) == 0, last);
    end
  endtask

  initial begin
    logic [7:0] sym;
    logic       dflt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, start of the long chain
    send_beat(in_beat_t'{FUNC_STEP, 8'h00, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF});
    define_elem(8'hFF, 1'b0, 1'b0);
    define_elem(8'hA5, 1'b1, 1'b0);
    define_elem(8'h00, 1'b0, 1'b0);
    step_code(8'hFF);
    step_code(8'h3C);
    step_code(8'h00);
    step_code(8'h00);
    step_code(8'hFF);
    path = '{8'hFF, 8'hA5, 8'h00};
    path_dflt = '{1'b0, 1'b1, 1'b0};
    walk = 1;

    // no final stored yet, so the chain uses up every state number
    for (int n = 0; n < STATE_COUNT - 4; n++) begin
      sym = 8'($urandom);
      dflt = ($urandom_range(0, 15) == 0);
      define_elem(sym, dflt, 1'b0);
      path.push_back(sym);
      path_dflt.push_back(dflt);
      while ($urandom_range(0, 2) == 0)
        walk_step();
    end
    define_elem(8'($urandom), 1'b0, 1'b0);
    define_elem(8'($urandom), 1'b1, 1'b0);
    define_elem(8'($urandom), 1'b0, 1'b1);

    // last free entry, then a full table
    define_elem(8'hFF, 1'b0, 1'b0);
    send_beat(in_beat_t'{FUNC_DEFINE, 8'h3C, 1'b0, 1'b1, 16'hFFFF, 16'h8001});
    step_code(8'hFF);
    step_code(8'h3C);
    step_code(8'hFF);
    step_code(8'h3C);
    define_elem(8'hFF, 1'b0, 1'b0);
    define_elem(8'h3C, 1'b0, 1'b1);
    define_elem(8'hFF, 1'b0, 1'b0);
    define_elem(8'h77, 1'b0, 1'b1);
    define_elem(8'hFF, 1'b0, 1'b0);
    define_elem(8'h3C, 1'b0, 1'b0);
    define_elem(8'hFF, 1'b0, 1'b1);
    define_elem(8'h12, 1'b0, 1'b0);
    define_elem(8'h34, 1'b0, 1'b0);
    define_elem(8'h56, 1'b0, 1'b1);
    walk = 0;

    while (beats_sent < ITEMS_TOTAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: define_sequence();
        4, 5, 6: repeat ($urandom_range(1, 12)) walk_step();
        7: begin
          step_code(8'($urandom));
          step_code(8'hFF);
          step_code(8'h3C);
          walk = 0;
        end
        default: begin
          send_beat(rand_beat());
          walk = 0;
        end
      endcase
    end
    in_valid <= 1'b0;

    while (awaited != 0)
      @(negedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0 && awaited == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
